[rtl/bfhs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfhs_pkg
// Shared types and constants of the back/forward history store.
// ----------------------------------------------------------------------------
package bfhs_pkg;

	// Default sizing of the history ring.
	localparam int DEPTH_DEFAULT       = 256;
	localparam int ENTRY_WIDTH_DEFAULT = 32;

	// Fixed widths of the word fields on the ports.
	localparam int ACTION_W = 3;
	localparam int FIELD_W  = 32;
	localparam int COUNT_W  = 9;

	// Action codes of a command word.
	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD          = 3'd0,
		ACT_BACK         = 3'd1,
		ACT_FORWARD      = 3'd2,
		ACT_PEEK_BACK    = 3'd3,
		ACT_PEEK_FORWARD = 3'd4
	} action_t;

endpackage
`default_nettype wire

[rtl/back_forward_history_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// back_forward_history_store
// Bounded back/forward navigation history kept in a ring memory, with a
// count of stored entries and a cursor counted from the oldest entry.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  -------   --------------   ---------------------------------------------
//  command   start / busy     action, entry_value
//  result    done (strobe)    ok, entry_out, can_back, can_forward,
//                             history_count
//
// At the accepting edge of a command word the pointers (oldest slot, count,
// cursor) are updated, an add writes its slot and a move or peek issues its
// read to the single-port ring memory. The memory returns the entry in the
// following cycle, and in that cycle done is high with the result. busy is
// high during that cycle, so no command is taken while a result is shown.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the pointers and the result flags only; the ring needs no
// clearing because reads never reach a slot outside the stored range.
//
module back_forward_history_store #(
	parameter int DEPTH       = bfhs_pkg::DEPTH_DEFAULT,
	parameter int ENTRY_WIDTH = bfhs_pkg::ENTRY_WIDTH_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [bfhs_pkg::ACTION_W-1:0]    action,
	input  wire logic [bfhs_pkg::FIELD_W-1:0]     entry_value,
	output logic                                  done,
	output logic                                  ok,
	output logic [bfhs_pkg::FIELD_W-1:0]          entry_out,
	output logic                                  can_back,
	output logic                                  can_forward,
	output logic [bfhs_pkg::COUNT_W-1:0]          history_count
);

	// Slot index width and count width (the count can hold DEPTH itself).
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
	localparam logic [CW-1:0] COUNT_LAST = CW'(DEPTH - 1);
	localparam logic [SW-1:0] SUM_DEPTH  = SW'(DEPTH);
	localparam logic [AW-1:0] SLOT_LAST  = AW'(DEPTH - 1);

	// Pointer state.
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;

	// Result stage.
	logic                   done_s1;
	logic                   ok_s1;
	logic                   add_s1;
	logic [ENTRY_WIDTH-1:0] value_s1;
	logic [ENTRY_WIDTH-1:0] rd_data_s1;

	// The ring itself.
	logic [ENTRY_WIDTH-1:0] ring_mem [DEPTH];

	logic                   accept;
	logic                   may_back;
	logic                   may_forward;
	logic [ENTRY_WIDTH-1:0] value_w;

	logic [AW-1:0]          oldest_d;
	logic [CW-1:0]          count_d;
	logic [CW-1:0]          cursor_d;
	logic                   ok_d;
	logic                   add_d;
	logic                   wr_en;
	logic                   rd_en;
	logic [CW-1:0]          offset;
	logic [AW-1:0]          base_slot;
	logic [SW-1:0]          slot_sum;
	logic [AW-1:0]          slot;

	assign accept  = start && !busy;
	assign value_w = ENTRY_WIDTH'(entry_value);

	// Moves are checked against the state before the command.
	assign may_back    = (count_q != '0) && (cursor_q != '0);
	assign may_forward = (count_q != '0) && (cursor_q < count_q - CW'(1));

	// Next pointers and the slot offset that the command touches.
	always_comb begin
		oldest_d = oldest_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		ok_d     = 1'b0;
		add_d    = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		offset   = cursor_q;
		case (bfhs_pkg::action_t'(action))
			bfhs_pkg::ACT_ADD: begin
				// offset is the position of the new entry after trimming.
				if (count_q == '0) begin
					oldest_d = '0;
					offset   = '0;
				end else if (cursor_q >= count_q - CW'(1)) begin
					if (count_q >= COUNT_FULL) begin
						oldest_d = (oldest_q == SLOT_LAST) ? '0 : oldest_q + AW'(1);
						offset   = COUNT_LAST;
					end else begin
						offset = count_q;
					end
				end else begin
					offset = cursor_q + CW'(1);
				end
				count_d  = offset + CW'(1);
				cursor_d = offset;
				ok_d     = 1'b1;
				add_d    = 1'b1;
				wr_en    = 1'b1;
			end
			bfhs_pkg::ACT_BACK: begin
				if (may_back) begin
					cursor_d = cursor_q - CW'(1);
					offset   = cursor_q - CW'(1);
					ok_d     = 1'b1;
					rd_en    = 1'b1;
				end
			end
			bfhs_pkg::ACT_FORWARD: begin
				if (may_forward) begin
					cursor_d = cursor_q + CW'(1);
					offset   = cursor_q + CW'(1);
					ok_d     = 1'b1;
					rd_en    = 1'b1;
				end
			end
			bfhs_pkg::ACT_PEEK_BACK: begin
				if (may_back) begin
					offset = cursor_q - CW'(1);
					ok_d   = 1'b1;
					rd_en  = 1'b1;
				end
			end
			bfhs_pkg::ACT_PEEK_FORWARD: begin
				if (may_forward) begin
					offset = cursor_q + CW'(1);
					ok_d   = 1'b1;
					rd_en  = 1'b1;
				end
			end
			default: begin
				// Unknown codes leave the history untouched.
				ok_d = 1'b0;
			end
		endcase
	end

	// Ring slot of the touched offset. Both terms stay below DEPTH, so one
	// compare and subtract wraps the sum.
	assign base_slot = add_d ? oldest_d : oldest_q;
	assign slot_sum  = SW'(base_slot) + SW'(offset);
	always_comb begin
		if (slot_sum >= SUM_DEPTH) begin
			slot = AW'(slot_sum - SUM_DEPTH);
		end else begin
			slot = AW'(slot_sum);
		end
	end

	// Pointer and result stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			done_s1  <= 1'b0;
			ok_s1    <= 1'b0;
			add_s1   <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				oldest_q <= oldest_d;
				count_q  <= count_d;
				cursor_q <= cursor_d;
				ok_s1    <= ok_d;
				add_s1   <= add_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= value_w;
		end
	end

	// Single-port ring: an add writes, a move or peek reads.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ring_mem[slot] <= value_w;
		end
		if (accept && rd_en) begin
			rd_data_s1 <= ring_mem[slot];
		end
	end

	// The result cycle doubles as the busy cycle.
	assign busy = done_s1;
	assign done = done_s1;
	assign ok   = ok_s1;

	always_comb begin
		if (!ok_s1) begin
			entry_out = '0;
		end else if (add_s1) begin
			entry_out = bfhs_pkg::FIELD_W'(value_s1);
		end else begin
			entry_out = bfhs_pkg::FIELD_W'(rd_data_s1);
		end
	end

	// Status after the step, taken from the updated pointers.
	assign can_back      = may_back;
	assign can_forward   = may_forward;
	assign history_count = bfhs_pkg::COUNT_W'(count_q);

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the back/forward history store. An in-bench
// predictor tracks the history ring, count and cursor, and every result word
// is checked against it while commands arrive with or without random gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import bfhs_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_WAIT = 8;

	// Action codes that the block does not define; such words must be ignored.
	localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

	// One result word as the block reports it.
	typedef struct {
		logic               ok;
		logic [FIELD_W-1:0] entry;
		logic               can_back;
		logic               can_fwd;
		logic [COUNT_W-1:0] count;
	} nav_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ACTION_W-1:0] action;
	logic [FIELD_W-1:0]  entry_value;
	logic                done;
	logic                ok;
	logic [FIELD_W-1:0]  entry_out;
	logic                can_back;
	logic                can_forward;
	logic [COUNT_W-1:0]  history_count;

	// Predicted history: ring of handles, slot of the oldest entry, number of
	// stored entries and cursor counted from the oldest entry.
	logic [FIELD_W-1:0] hist_ring [DEPTH];
	int                 hist_oldest;
	int                 hist_count;
	int                 hist_cursor;

	// Result words predicted at acceptance and not yet seen on the ports.
	nav_result_t awaited_results [$];

	bit gaps_on;
	int words_sent;
	int results_checked;
	int mismatches;
	int adds_on_full;
	int branch_cuts;
	int cycle_count;

	back_forward_history_store u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.entry_value   (entry_value),
		.done          (done),
		.ok            (ok),
		.entry_out     (entry_out),
		.can_back      (can_back),
		.can_forward   (can_forward),
		.history_count (history_count)
	);

	always #10 clk = ~clk;

	// A hung handshake must not keep the run alive forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic bit step_back_allowed();
		return hist_count > 0 && hist_cursor > 0;
	endfunction

	function automatic bit step_fwd_allowed();
		return hist_count > 0 && hist_cursor < hist_count - 1;
	endfunction

	function automatic logic [FIELD_W-1:0] ring_at(input int offset);
		return hist_ring[(hist_oldest + offset) % DEPTH];
	endfunction

	// Applies one command word to the predicted history and returns the result
	// word that the block must report for it.
	function automatic nav_result_t navigate(input logic [ACTION_W-1:0] act,
			input logic [FIELD_W-1:0] value);
		nav_result_t r;
		r.ok    = 1'b0;
		r.entry = '0;
		case (act)
			ACT_ADD: begin
				if (hist_count == 0) begin
					// The first entry always lands in slot zero.
					hist_oldest = 0;
				end else if (hist_cursor >= hist_count - 1) begin
					// Appending at the newest entry; a full ring loses its oldest.
					if (hist_count >= DEPTH) begin
						hist_oldest = (hist_oldest + 1) % DEPTH;
						hist_count  = DEPTH - 1;
						adds_on_full++;
					end
				end else begin
					// Cursor is mid-history: the forward branch is thrown away.
					hist_count = hist_cursor + 1;
					branch_cuts++;
				end
				hist_ring[(hist_oldest + hist_count) % DEPTH] = value;
				hist_count++;
				hist_cursor = hist_count - 1;
				r.ok    = 1'b1;
				r.entry = value;
			end
			ACT_BACK: begin
				if (step_back_allowed()) begin
					hist_cursor--;
					r.ok    = 1'b1;
					r.entry = ring_at(hist_cursor);
				end
			end
			ACT_FORWARD: begin
				if (step_fwd_allowed()) begin
					hist_cursor++;
					r.ok    = 1'b1;
					r.entry = ring_at(hist_cursor);
				end
			end
			ACT_PEEK_BACK: begin
				if (step_back_allowed()) begin
					r.ok    = 1'b1;
					r.entry = ring_at(hist_cursor - 1);
				end
			end
			ACT_PEEK_FORWARD: begin
				if (step_fwd_allowed()) begin
					r.ok    = 1'b1;
					r.entry = ring_at(hist_cursor + 1);
				end
			end
			default: begin
			end
		endcase
		r.can_back = step_back_allowed();
		r.can_fwd  = step_fwd_allowed();
		r.count    = hist_count[COUNT_W-1:0];
		return r;
	endfunction

	// Handles lean toward the all-zero and all-one corners now and then.
	function automatic logic [FIELD_W-1:0] pick_handle();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Result checker. Ports are sampled at the edge that ends the strobe
	// cycle, so the values seen are the ones held during that cycle.
	always @(posedge clk) begin
		nav_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: result word with nothing awaited (ok=%0d entry=%h)",
						ok, entry_out);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				if (ok !== want.ok || entry_out !== want.entry
						|| can_back !== want.can_back || can_forward !== want.can_fwd
						|| history_count !== want.count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d expected: ok=%0d entry=%h back=%0d fwd=%0d count=%0d",
							results_checked, want.ok, want.entry, want.can_back,
							want.can_fwd, want.count);
						$display("result %0d got:      ok=%0d entry=%h back=%0d fwd=%0d count=%0d",
							results_checked, ok, entry_out, can_back, can_forward,
							history_count);
					end
				end
			end
		end
	end

	// Lowers start for the requested idle time and wiggles the payload, which the
	// block must ignore while start is low.
	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) begin
			action      <= ACTION_W'($urandom);
			entry_value <= $urandom;
			@(posedge clk);
		end
	endtask

	// Presents one command word and holds it until the block takes it. The
	// expectation is formed at the accepting edge. Unless an idle gap follows,
	// start stays high on return so that a following word goes out back to back.
	task automatic send_word(input logic [ACTION_W-1:0] act,
			input logic [FIELD_W-1:0] value);
		start       <= 1'b1;
		action      <= act;
		entry_value <= value;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		awaited_results.push_back(navigate(act, value));
		words_sent++;
		if (gaps_on && $urandom_range(0, 3) == 0)
			idle_for($urandom_range(1, 9));
	endtask

	// Holds the sender off until every awaited result word has come back.
	// It always waits on a clock edge, so start never toggles twice in a step.
	task automatic wait_results_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Every move and peek on an empty history fails, and an unused code too.
	task automatic test_empty_history();
		gaps_on = 1'b1;
		send_word(ACT_BACK, pick_handle());
		send_word(ACT_FORWARD, pick_handle());
		send_word(ACT_PEEK_BACK, pick_handle());
		send_word(ACT_PEEK_FORWARD, pick_handle());
		send_word(ACT_UNUSED_LAST, '1);
	endtask

	// A short history walked to both ends, then cut mid-way by an add.
	task automatic test_add_and_walk();
		gaps_on = 1'b1;
		send_word(ACT_ADD, '0);
		send_word(ACT_ADD, '1);
		send_word(ACT_ADD, 32'hA5A5_A5A5);
		send_word(ACT_PEEK_FORWARD, pick_handle());
		send_word(ACT_FORWARD, pick_handle());
		send_word(ACT_BACK, pick_handle());
		send_word(ACT_BACK, pick_handle());
		// The cursor is at the oldest entry now; nothing is behind it.
		send_word(ACT_BACK, pick_handle());
		send_word(ACT_PEEK_BACK, pick_handle());
		send_word(ACT_PEEK_FORWARD, pick_handle());
		send_word(ACT_UNUSED_FIRST, '0);
		send_word(ACT_FORWARD, pick_handle());
		// Adding here drops the newest entry that lay ahead of the cursor.
		send_word(ACT_ADD, 32'h5A5A_5A5A);
		send_word(ACT_FORWARD, pick_handle());
		send_word(ACT_PEEK_BACK, pick_handle());
		send_word(ACT_BACK, pick_handle());
		send_word(ACT_FORWARD, pick_handle());
	endtask

	// Random navigation built from short runs of one kind of command, so that
	// histories grow, get walked back and get cut. A small share is noise.
	task automatic test_random_walk(input int n_words, input bit allow_gaps);
		int sent;
		int run;
		int pick;
		sent    = 0;
		gaps_on = allow_gaps;
		while (sent < n_words) begin
			pick = $urandom_range(0, 99);
			run  = $urandom_range(1, 5);
			if (allow_gaps && $urandom_range(0, 7) == 0)
				gaps_on = !gaps_on;
			for (int k = 0; k < run; k++) begin
				if (pick < 35)
					send_word(ACT_ADD, pick_handle());
				else if (pick < 55)
					send_word(ACT_BACK, pick_handle());
				else if (pick < 70)
					send_word(ACT_FORWARD, pick_handle());
				else if (pick < 80)
					send_word(ACT_PEEK_BACK, pick_handle());
				else if (pick < 90)
					send_word(ACT_PEEK_FORWARD, pick_handle());
				else if (pick < 95)
					send_word(ACTION_W'($urandom), pick_handle());
				else
					send_word(ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
						pick_handle());
			end
			sent += run;
		end
	endtask

	// Fills the ring past its depth so the oldest entries fall off, then
	// walks back and cuts the forward branch of a full history.
	task automatic test_full_ring();
		int adds;
		adds    = 0;
		gaps_on = 1'b1;
		while (adds < DEPTH + 40) begin
			send_word(ACT_ADD, pick_handle());
			adds++;
			if ($urandom_range(0, 7) == 0)
				send_word($urandom_range(0, 1) ? ACT_PEEK_BACK : ACT_PEEK_FORWARD,
					pick_handle());
			if (adds % 64 == 0)
				gaps_on = !gaps_on;
		end
		repeat (30) send_word(ACT_BACK, pick_handle());
		send_word(ACT_PEEK_FORWARD, pick_handle());
		send_word(ACT_ADD, pick_handle());
		send_word(ACT_FORWARD, pick_handle());
		repeat (12) send_word(ACT_BACK, pick_handle());
		repeat (12) send_word(ACT_FORWARD, pick_handle());
	endtask

	// Closing stretch with the command side never idle.
	task automatic test_back_to_back();
		test_random_walk(60, 1'b0);
	endtask

	initial begin
		arst_n          <= 1'b0;
		start           <= 1'b0;
		action          <= ACT_ADD;
		entry_value     <= '0;
		gaps_on         = 1'b1;
		words_sent      = 0;
		results_checked = 0;
		mismatches      = 0;
		adds_on_full    = 0;
		branch_cuts     = 0;
		cycle_count     = 0;
		hist_oldest     = 0;
		hist_count      = 0;
		hist_cursor     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_history();
		test_add_and_walk();
		wait_results_drained();
		test_random_walk(90, 1'b1);
		test_full_ring();
		wait_results_drained();
		test_back_to_back();

		wait_results_drained();
		repeat (SETTLE_WAIT) @(posedge clk);
		if (awaited_results.size() != 0)
			mismatches++;

		$display("Run covered %0d command words and %0d checked results,", words_sent,
			results_checked);
		$display("with %0d adds onto a full ring and %0d adds that cut a forward branch.",
			adds_on_full, branch_cuts);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
